// File: rtl/core/mbx_pkg.sv
// shared types and codes of the per-task message mailbox
package mbx_pkg;

   // operation codes of a request transaction
   localparam logic CMD_SEND = 1'b0;
   localparam logic CMD_RECV = 1'b1;

   // status codes of a response transaction
   typedef logic [1:0] status_type;
   localparam status_type STAT_OK       = 2'd0;
   localparam status_type STAT_NO_TASK  = 2'd1;
   localparam status_type STAT_FULL     = 2'd2;
   localparam status_type STAT_EMPTY    = 2'd3;

   // presence mask covers task ids below this
   localparam int MASK_BITS = 16;

   // one stored message
   typedef struct packed {
      logic [3:0]         sender;
      logic signed [31:0] kind;
      logic [63:0]        word_a;
      logic [63:0]        word_b;
      logic [63:0]        word_c;
   } msg_type;

endpackage

// File: rtl/core/mbx_msg_ram.sv
// message store: single write port, single read port, registered read data
module mbx_msg_ram #(
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  mbx_pkg::msg_type         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output mbx_pkg::msg_type         rd_data
);
   import mbx_pkg::*;

   msg_type mem_ff [DEPTH];
   msg_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/per_task_message_mailbox_unit.sv
// top level of the per-task message mailbox: queue counters, sequencer, output register
//
//  channel  direction  handshake           payload
//  req_     in         req_valid/req_stall  cmd, self_id, dest_id, msg_kind, word_a..c
//  rsp_     out        rsp_valid/rsp_stall  status, got_sender, got_kind, got_a..c
//  csr_     in         csr_we               csr_wdata = task present mask
//
// a transaction goes from accept to the output register by reading the queue counter
// memory, then updating it and touching the message store, then collecting the
// message store read data. the next request is taken after that.
// reset clears the mask to task 0 only and marks every counter entry as zero through
// per-task valid flops; the message store is not cleared.
// a stalled response holds the sequencer in its final step until the output frees.
module per_task_message_mailbox_unit #(
   parameter int NUM_TASKS   = 16,
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_cmd,
   input  logic [3:0]                req_self_id,
   input  logic [7:0]                req_dest_id,
   input  logic signed [31:0]        req_msg_kind,
   input  logic [63:0]               req_word_a,
   input  logic [63:0]               req_word_b,
   input  logic [63:0]               req_word_c,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output mbx_pkg::status_type       rsp_status,
   output logic [3:0]                rsp_got_sender,
   output logic signed [31:0]        rsp_got_kind,
   output logic [63:0]               rsp_got_a,
   output logic [63:0]               rsp_got_b,
   output logic [63:0]               rsp_got_c,
   // configuration
   input  logic                      csr_we,
   input  logic [15:0]               csr_wdata
);
   import mbx_pkg::*;

   localparam int TW    = $clog2(NUM_TASKS);
   localparam int IW    = $clog2(QUEUE_DEPTH);
   localparam int CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int SLOTS = NUM_TASKS * QUEUE_DEPTH;
   localparam int AW    = $clog2(SLOTS);

   // sequencer codes
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CNT  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   // per-task queue bookkeeping
   typedef struct packed {
      logic [IW-1:0] rd_idx;
      logic [IW-1:0] wr_idx;
      logic [CW-1:0] fill;
   } cnt_type;

   logic [1:0]  state_ff, state_in;
   logic [15:0] mask_ff;

   // captured request
   logic          cmd_ff;
   logic [TW-1:0] task_ff;
   logic          ok_ff;
   msg_type       msg_ff;

   // counter memory, with valid flops standing in for a clear
   cnt_type        cnt_mem_ff [NUM_TASKS];
   cnt_type        cnt_rd_ff;
   logic           cnt_rd_vld_ff;
   logic [NUM_TASKS-1:0] cnt_vld_ff;

   // result of the update step
   status_type status_ff, status_in;
   logic       hit_ff, hit_in;

   // output register
   logic       rsp_valid_ff;
   status_type rsp_status_ff;
   msg_type    rsp_msg_ff;

   logic          accept;
   logic          rsp_free;
   logic [TW-1:0] task_in;
   logic          ok_in;
   cnt_type       cur;
   cnt_type       cnt_wdata;
   logic          cnt_we;
   logic          ram_we, ram_re;
   logic [AW-1:0] ram_waddr, ram_raddr, base_addr;
   msg_type       ram_rdata;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // task slot, range check and, for a send, presence check at accept time
   always_comb begin
      if (req_cmd == CMD_SEND) begin
         task_in = req_dest_id[TW-1:0];
         ok_in   = (int'(req_dest_id) < NUM_TASKS) && (int'(req_dest_id) < MASK_BITS)
                   && mask_ff[req_dest_id[3:0]];
      end else begin
         task_in = TW'(req_self_id);
         ok_in   = (int'(req_self_id) < NUM_TASKS);
      end
   end

   // mask register
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= 16'd1;
      end else if (csr_we) begin
         mask_ff <= csr_wdata;
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff         <= req_cmd;
         task_ff        <= task_in;
         ok_ff          <= ok_in;
         msg_ff.sender  <= req_self_id;
         msg_ff.kind    <= req_msg_kind;
         msg_ff.word_a  <= req_word_a;
         msg_ff.word_b  <= req_word_b;
         msg_ff.word_c  <= req_word_c;
      end
   end

   // counter memory: read at accept, written back in the update step
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem_ff[task_ff] <= cnt_wdata;
      end
      if (accept) begin
         cnt_rd_ff <= cnt_mem_ff[task_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_vld_ff    <= '0;
         cnt_rd_vld_ff <= 1'b0;
      end else begin
         if (cnt_we) begin
            cnt_vld_ff[task_ff] <= 1'b1;
         end
         if (accept) begin
            // out-of-range slots are never used, read them as empty
            cnt_rd_vld_ff <= ok_in && cnt_vld_ff[task_in];
         end
      end
   end

   // an entry never written reads as all zero
   assign cur = cnt_rd_vld_ff ? cnt_rd_ff : '0;

   assign base_addr = AW'(task_ff) * AW'(QUEUE_DEPTH);

   // update step: decide status, bump indexes, touch the message store
   always_comb begin
      cnt_wdata = cur;
      cnt_we    = 1'b0;
      ram_we    = 1'b0;
      ram_re    = 1'b0;
      ram_waddr = base_addr + AW'(cur.wr_idx);
      ram_raddr = base_addr + AW'(cur.rd_idx);
      status_in = status_ff;
      hit_in    = hit_ff;
      if (state_ff == ST_CNT) begin
         hit_in = 1'b0;
         if (cmd_ff == CMD_SEND) begin
            if (!ok_ff) begin
               status_in = STAT_NO_TASK;
            end else if (cur.fill == CW'(QUEUE_DEPTH)) begin
               status_in = STAT_FULL;
            end else begin
               status_in        = STAT_OK;
               ram_we           = 1'b1;
               cnt_we           = 1'b1;
               cnt_wdata.wr_idx = (cur.wr_idx == IW'(QUEUE_DEPTH - 1)) ? '0
                                  : cur.wr_idx + 1'b1;
               cnt_wdata.fill   = cur.fill + 1'b1;
            end
         end else begin
            if (!ok_ff || cur.fill == '0) begin
               status_in = STAT_EMPTY;
            end else begin
               status_in        = STAT_OK;
               hit_in           = 1'b1;
               ram_re           = 1'b1;
               cnt_we           = 1'b1;
               cnt_wdata.rd_idx = (cur.rd_idx == IW'(QUEUE_DEPTH - 1)) ? '0
                                  : cur.rd_idx + 1'b1;
               cnt_wdata.fill   = cur.fill - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      hit_ff    <= hit_in;
   end

   mbx_msg_ram #(
      .DEPTH (SLOTS)
   ) u_msg_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (msg_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_CNT;
            end
         end
         ST_CNT: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // output register: loaded in the final step once free
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_FIN && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FIN && rsp_free) begin
         rsp_status_ff <= status_ff;
         // only a successful receive returns message fields
         rsp_msg_ff    <= hit_ff ? ram_rdata : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_got_sender = rsp_msg_ff.sender;
   assign rsp_got_kind   = rsp_msg_ff.kind;
   assign rsp_got_a      = rsp_msg_ff.word_a;
   assign rsp_got_b      = rsp_msg_ff.word_b;
   assign rsp_got_c      = rsp_msg_ff.word_c;

endmodule
